// ===== design/krts_pkg.sv =====
// Package for the keyed record table sorter: item types, opcodes, status codes.
// No dependencies.
package krts_pkg;

  localparam int DefaultDepth = 32;
  localparam int MaxResults   = 32;
  localparam logic [11:0] SmallMax = 12'hFFF;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_FIND   = 3'd2;
  localparam logic [2:0] OP_UPDATE = 3'd3;
  localparam logic [2:0] OP_SORT   = 3'd4;
  localparam logic [2:0] OP_LIST   = 3'd5;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_DUP   = 3'd1;
  localparam logic [2:0] ST_NOTFD = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;

  localparam logic [1:0] SEL_RUNS    = 2'd0;
  localparam logic [1:0] SEL_WICKETS = 2'd1;
  localparam logic [1:0] SEL_MATCHES = 2'd2;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [9:0]  key;
    logic [15:0] runs_in;
    logic [11:0] wickets_in;
    logic [11:0] matches_in;
    logic [1:0]  field_select;
    logic        descending;
    logic [15:0] new_value;
    logic [6:0]  list_limit;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  position;
    logic [9:0]  key_out;
    logic [15:0] runs_out;
    logic [11:0] wickets_out;
    logic [11:0] matches_out;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [9:0]  key;
    logic [15:0] runs;
    logic [11:0] wickets;
    logic [11:0] match_cnt;
  } rec_t;

  // datapath operation requested by the controller
  typedef enum logic [3:0] {
    DP_NOP, DP_RD_I, DP_RD_J, DP_WR_I, DP_WR_J, DP_WR_NEW, DP_WR_UPD, DP_SHIFT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [5:0] addr;
  } dp_cmd_t;

  typedef struct packed {
    rec_t rec_i;
    rec_t rec_j;
  } dp_stat_t;

endpackage

// ===== design/keyed_record_table_sorter_top.sv =====
// Keyed record table sorter: one command at a time, then one or more results
// for each of the six opcodes (the two other codes give none). A command walks
// the table entries it searches or shifts, reads both records of each sort
// compare and writes both back when the compare exchanges (single-port record
// memory), and reads each listed record in turn. Results come with strobe
// result_valid for one cycle each and the receiver cannot stall them. Depends on krts_pkg.
module keyed_record_table_sorter_top #(
  parameter int TableDepth = krts_pkg::DefaultDepth
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  krts_pkg::in_item_t  in_item,
  output logic                busy,
  output logic                result_valid,
  output krts_pkg::out_item_t result
);
  import krts_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  rec_t     wdata;

  krts_ctrl #(.TableDepth(TableDepth)) u_ctrl (
    .clk, .rst, .start, .in_item, .busy, .result_valid, .result,
    .cmd, .wdata, .stat
  );

  krts_datapath #(.TableDepth(TableDepth)) u_dp (
    .clk, .cmd, .wdata, .stat
  );
endmodule

// ===== design/krts_datapath.sv =====
// Datapath of the keyed record table sorter: record memory and two read registers.
// Depends on krts_pkg.
module krts_datapath #(
  parameter int TableDepth = krts_pkg::DefaultDepth,
  parameter int AW = $clog2(TableDepth)
) (
  input  logic               clk,
  input  krts_pkg::dp_cmd_t  cmd,
  input  krts_pkg::rec_t     wdata,
  output krts_pkg::dp_stat_t stat
);
  import krts_pkg::*;

  rec_t mem [TableDepth];
  rec_t rec_i;
  rec_t rec_j;
  logic [AW-1:0] a;

  assign a = cmd.addr[AW-1:0];
  assign stat.rec_i = rec_i;
  assign stat.rec_j = rec_j;

  // single port memory with registered read into slot i or j
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_RD_I: rec_i <= mem[a];
      DP_RD_J: rec_j <= mem[a];
      DP_WR_I: mem[a] <= rec_j;
      DP_WR_J: mem[a] <= rec_i;
      DP_WR_NEW, DP_WR_UPD: begin
        mem[a] <= wdata;
        rec_i  <= wdata;
      end
      DP_SHIFT: mem[a] <= rec_j;
      default: ;
    endcase
  end
endmodule

// ===== design/krts_ctrl.sv =====
// Controller of the keyed record table sorter: sequences search, shift, sort, list.
// Depends on krts_pkg.
module krts_ctrl #(
  parameter int TableDepth = krts_pkg::DefaultDepth,
  parameter int CW = $clog2(TableDepth + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  krts_pkg::in_item_t in_item,
  output logic               busy,
  output logic               result_valid,
  output krts_pkg::out_item_t result,
  output krts_pkg::dp_cmd_t  cmd,
  output krts_pkg::rec_t     wdata,
  input  krts_pkg::dp_stat_t stat
);
  import krts_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_SRCH  = 13'b0000000000010,
    S_SCMP  = 13'b0000000000100,
    S_DEC   = 13'b0000000001000,
    S_WR    = 13'b0000000010000,
    S_SHRD  = 13'b0000000100000,
    S_SHWR  = 13'b0000001000000,
    S_SRI   = 13'b0000010000000,
    S_SRJ   = 13'b0000100000000,
    S_SCP   = 13'b0001000000000,
    S_SWJ   = 13'b0010000000000,
    S_LRD   = 13'b0100000000000,
    S_LOUT  = 13'b1000000000000
  } state_t;

  state_t state;
  in_item_t it;
  logic [CW-1:0] count;
  logic [CW-1:0] i;
  logic [CW-1:0] j;
  logic [CW-1:0] n_out;
  logic          found;
  logic [CW-1:0] fidx;
  logic [15:0]   va, vb;
  logic          swap;
  logic [11:0]   sat;
  rec_t          upd;
  logic [7:0]    lim_clamp;

  assign busy = (state != S_IDLE);

  // counter of the selected field, zero extended
  function automatic logic [15:0] ctr(rec_t r, logic [1:0] s);
    case (s)
      SEL_RUNS:    ctr = r.runs;
      SEL_WICKETS: ctr = {4'd0, r.wickets};
      default:     ctr = {4'd0, r.match_cnt};
    endcase
  endfunction

  assign va   = ctr(stat.rec_i, it.field_select);
  assign vb   = ctr(stat.rec_j, it.field_select);
  assign swap = it.descending ? (va < vb) : (va > vb);
  assign sat  = (it.new_value > 16'(SmallMax)) ? SmallMax : it.new_value[11:0];

  // clamp the listing limit to the most results an item may cause
  assign lim_clamp = (in_item.list_limit > 7'(MaxResults)) ? 8'(MaxResults) :
                     {1'b0, in_item.list_limit};

  always_comb begin
    upd = stat.rec_i;
    case (it.field_select)
      SEL_RUNS:    upd.runs = it.new_value;
      SEL_WICKETS: upd.wickets = sat;
      SEL_MATCHES: upd.match_cnt = sat;
      default: ;
    endcase
    wdata = (it.opcode == OP_ADD) ?
      rec_t'{key: it.key, runs: it.runs_in, wickets: it.wickets_in,
             match_cnt: it.matches_in} : upd;
  end

  // datapath command per state
  always_comb begin
    cmd = '{op: DP_NOP, addr: '0};
    unique case (state)
      S_SRCH: cmd = '{op: DP_RD_I, addr: 6'(i)};
      S_WR: begin
        if (it.opcode == OP_ADD) cmd = '{op: DP_WR_NEW, addr: 6'(count)};
        else if (it.opcode == OP_UPDATE) cmd = '{op: DP_WR_UPD, addr: 6'(fidx)};
      end
      S_SHRD: cmd = '{op: DP_RD_J, addr: 6'(i + 1'b1)};
      S_SHWR: cmd = '{op: DP_SHIFT, addr: 6'(i)};
      S_SRI:  cmd = '{op: DP_RD_I, addr: 6'(i)};
      S_SRJ:  cmd = '{op: DP_RD_J, addr: 6'(j)};
      S_SCP:  if (swap) cmd = '{op: DP_WR_I, addr: 6'(i)};
      S_SWJ:  cmd = '{op: DP_WR_J, addr: 6'(j)};
      S_LRD:  cmd = '{op: DP_RD_I, addr: 6'(i)};
      default: ;
    endcase
  end

  // sequence one item
  always_ff @(posedge clk) begin
    result_valid <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (start) begin
          it <= in_item;
          i <= '0;
          found <= 1'b0;
          if (in_item.opcode == OP_SORT) begin
            j <= CW'(1);
            state <= S_SRI;
          end else if (in_item.opcode == OP_LIST) begin
            state <= S_LRD;
          end else if (in_item.opcode <= OP_UPDATE) begin
            state <= S_SRCH;
          end
          if (in_item.opcode == OP_SORT || in_item.opcode == OP_LIST) begin
            if (8'(count) < lim_clamp) n_out <= count;
            else n_out <= CW'(lim_clamp);
            if (in_item.opcode == OP_SORT &&
                (count < CW'(2) || in_item.field_select == 2'd3)) state <= S_LRD;
          end
        end
        S_SRCH: begin
          if (i >= count) state <= S_DEC;
          else state <= S_SCMP;
        end
        S_SCMP: begin
          if (stat.rec_i.key == it.key) begin
            found <= 1'b1;
            fidx <= i;
            state <= S_DEC;
          end else begin
            i <= i + 1'b1;
            state <= S_SRCH;
          end
        end
        S_DEC: begin
          state <= S_IDLE;
          result_valid <= 1'b1;
          result <= '0;
          result.last <= 1'b1;
          if (!found) begin
            if (it.opcode == OP_ADD) begin
              if (count >= CW'(TableDepth)) result.status <= ST_FULL;
              else state <= S_WR;
              result_valid <= (count >= CW'(TableDepth));
            end else begin
              result.status <= ST_NOTFD;
            end
          end else begin
            result.status <= (it.opcode == OP_ADD) ? ST_DUP : ST_OK;
            result.position <= 6'(fidx);
            result.key_out <= stat.rec_i.key;
            result.runs_out <= stat.rec_i.runs;
            result.wickets_out <= stat.rec_i.wickets;
            result.matches_out <= stat.rec_i.match_cnt;
            if (it.opcode == OP_UPDATE) begin
              result_valid <= 1'b0;
              state <= S_WR;
            end else if (it.opcode == OP_REMOVE) begin
              i <= fidx;
              count <= count - 1'b1;
              state <= (fidx + 1'b1 < count) ? S_SHRD : S_IDLE;
            end
          end
        end
        S_WR: begin
          result_valid <= 1'b1;
          result.status <= ST_OK;
          result.last <= 1'b1;
          result.position <= (it.opcode == OP_ADD) ? 6'(count) : 6'(fidx);
          result.key_out <= wdata.key;
          result.runs_out <= wdata.runs;
          result.wickets_out <= wdata.wickets;
          result.matches_out <= wdata.match_cnt;
          if (it.opcode == OP_ADD) count <= count + 1'b1;
          state <= S_IDLE;
        end
        S_SHRD: state <= S_SHWR;
        S_SHWR: begin
          i <= i + 1'b1;
          // count already decremented: shift again while i+1 < new count
          state <= (i + 1'b1 < count) ? S_SHRD : S_IDLE;
        end
        S_SRI: state <= S_SRJ;
        S_SRJ: state <= S_SCP;
        S_SCP: begin
          if (swap) state <= S_SWJ;
          else if (j + 1'b1 < count) begin
            j <= j + 1'b1;
            state <= S_SRI;
          end else if (i + CW'(2) < count) begin
            i <= i + 1'b1;
            j <= i + CW'(2);
            state <= S_SRI;
          end else begin
            i <= '0;
            state <= S_LRD;
          end
        end
        S_SWJ: begin
          if (j + 1'b1 < count) begin
            j <= j + 1'b1;
            state <= S_SRI;
          end else if (i + CW'(2) < count) begin
            i <= i + 1'b1;
            j <= i + CW'(2);
            state <= S_SRI;
          end else begin
            i <= '0;
            state <= S_LRD;
          end
        end
        S_LRD: begin
          if (n_out == '0) begin
            result_valid <= 1'b1;
            result <= '0;
            result.status <= ST_EMPTY;
            result.last <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_LOUT;
          end
        end
        S_LOUT: begin
          result_valid <= 1'b1;
          result.status <= ST_OK;
          result.position <= 6'(i);
          result.key_out <= stat.rec_i.key;
          result.runs_out <= stat.rec_i.runs;
          result.wickets_out <= stat.rec_i.wickets;
          result.matches_out <= stat.rec_i.match_cnt;
          result.last <= (i + 1'b1 == n_out);
          i <= i + 1'b1;
          state <= (i + 1'b1 == n_out) ? S_IDLE : S_LRD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== verif/keyed_record_table_sorter_checker.sv =====
// Checker for the keyed record table sorter: mirrors the table, predicts each
// item's results and compares them with the result strobes. Depends on krts_pkg.
`timescale 1ns / 1ps
module keyed_record_table_sorter_checker #(
  parameter int TableDepth = krts_pkg::DefaultDepth
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  krts_pkg::in_item_t  in_item,
  input  logic                result_valid,
  input  krts_pkg::out_item_t result,
  output int                  fail_count,
  output int                  pending
);
  import krts_pkg::*;

  rec_t      table_mirror [TableDepth];
  int        rec_count;
  out_item_t expected_q [$];

  assign pending = expected_q.size();

  task automatic report_mismatch(input string what, input out_item_t got, input out_item_t exp);
    $display("%0t MISMATCH %s: got %h expected %h", $realtime, what, got, exp);
    fail_count++;
  endtask

  function automatic out_item_t make_result(logic [2:0] st, bit has, int idx, bit lst);
    out_item_t r;
    r = '0;
    r.status = st;
    if (has) begin
      r.position    = idx[5:0];
      r.key_out     = table_mirror[idx].key;
      r.runs_out    = table_mirror[idx].runs;
      r.wickets_out = table_mirror[idx].wickets;
      r.matches_out = table_mirror[idx].match_cnt;
    end
    r.last = lst;
    return r;
  endfunction

  function automatic int find_key(logic [9:0] k);
    for (int i = 0; i < rec_count; i++) if (table_mirror[i].key == k) return i;
    return -1;
  endfunction

  function automatic logic [15:0] counter(int idx, logic [1:0] sel);
    case (sel)
      SEL_RUNS:    return table_mirror[idx].runs;
      SEL_WICKETS: return {4'd0, table_mirror[idx].wickets};
      default:     return {4'd0, table_mirror[idx].match_cnt};
    endcase
  endfunction

  task automatic push_listing(logic [6:0] lim);
    int n;
    n = int'(lim);
    if (n > rec_count) n = rec_count;
    if (n > MaxResults) n = MaxResults;
    if (n == 0) expected_q.push_back(make_result(ST_EMPTY, 1'b0, 0, 1'b1));
    for (int i = 0; i < n; i++) expected_q.push_back(make_result(ST_OK, 1'b1, i, i + 1 == n));
  endtask

  // Advance the mirror for one accepted item and queue its results.
  task automatic predict_item(in_item_t it);
    int idx;
    logic [11:0] clipped;
    rec_t t;
    idx = find_key(it.key);
    clipped = (it.new_value > SmallMax) ? SmallMax : it.new_value[11:0];
    case (it.opcode)
      OP_ADD: begin
        if (idx >= 0) expected_q.push_back(make_result(ST_DUP, 1'b1, idx, 1'b1));
        else if (rec_count >= TableDepth)
          expected_q.push_back(make_result(ST_FULL, 1'b0, 0, 1'b1));
        else begin
          table_mirror[rec_count] = '{it.key, it.runs_in, it.wickets_in, it.matches_in};
          rec_count++;
          expected_q.push_back(make_result(ST_OK, 1'b1, rec_count - 1, 1'b1));
        end
      end
      OP_REMOVE, OP_FIND, OP_UPDATE: begin
        if (idx < 0) expected_q.push_back(make_result(ST_NOTFD, 1'b0, 0, 1'b1));
        else begin
          if (it.opcode == OP_UPDATE) begin
            case (it.field_select)
              SEL_RUNS:    table_mirror[idx].runs = it.new_value;
              SEL_WICKETS: table_mirror[idx].wickets = clipped;
              SEL_MATCHES: table_mirror[idx].match_cnt = clipped;
              default: ;
            endcase
          end
          expected_q.push_back(make_result(ST_OK, 1'b1, idx, 1'b1));
          if (it.opcode == OP_REMOVE) begin
            for (int i = idx; i + 1 < rec_count; i++) table_mirror[i] = table_mirror[i + 1];
            rec_count--;
          end
        end
      end
      OP_SORT: begin
        if (it.field_select != 2'd3) begin
          for (int i = 0; i < rec_count; i++)
            for (int j = i + 1; j < rec_count; j++)
              if (it.descending ? (counter(i, it.field_select) < counter(j, it.field_select))
                                : (counter(i, it.field_select) > counter(j, it.field_select))) begin
                t = table_mirror[i];
                table_mirror[i] = table_mirror[j];
                table_mirror[j] = t;
              end
        end
        push_listing(it.list_limit);
      end
      OP_LIST: push_listing(it.list_limit);
      default: ;
    endcase
  endtask

  // Predict on accepted items, compare on result strobes.
  always @(posedge clk) begin
    out_item_t exp;
    if (rst) begin
      rec_count  = 0;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (result_valid) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", result, '0);
        end else begin
          exp = expected_q.pop_front();
          if (result.status !== exp.status) report_mismatch("status", result, exp);
          else if (result.position !== exp.position) report_mismatch("position", result, exp);
          else if (result.key_out !== exp.key_out) report_mismatch("key", result, exp);
          else if (result.runs_out !== exp.runs_out) report_mismatch("runs", result, exp);
          else if (result.wickets_out !== exp.wickets_out)
            report_mismatch("wickets", result, exp);
          else if (result.matches_out !== exp.matches_out)
            report_mismatch("matches", result, exp);
          else if (result.last !== exp.last) report_mismatch("last", result, exp);
        end
      end
      if (start && !busy) predict_item(in_item);
    end
  end
endmodule

// ===== verif/keyed_record_table_sorter_top_tb.sv =====
// Testbench top for the keyed record table sorter: clock, reset, directed and
// random commands, verdict. Depends on krts_pkg and the checker module.
`timescale 1ns / 1ps
module keyed_record_table_sorter_top_tb;
  import krts_pkg::*;

  localparam int StallLimit = 20000;

  logic      clk = 0;
  logic      rst = 1;
  logic      start = 0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      result_valid;
  out_item_t result;
  int        fail_count;
  int        pending;
  int        idle_cycles = 0;
  bit        quiet_stretch = 0;
  logic [9:0] key_pool [$];

  always #5 clk = ~clk;

  keyed_record_table_sorter_top DUT (
    .clk(clk), .rst(rst), .start(start), .in_item(in_item),
    .busy(busy), .result_valid(result_valid), .result(result)
  );

  keyed_record_table_sorter_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .result_valid(result_valid), .result(result),
    .fail_count(fail_count), .pending(pending)
  );

  // Count cycles with nothing accepted and no result; end the run on a hang.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Hold one item until accepted, with an occasional gap first.
  // Start stays high after acceptance; drop it before any wait.
  task automatic send(in_item_t it);
    if (!quiet_stretch) begin
      while ($urandom_range(99) < 14) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic in_item_t cmd(logic [2:0] op, logic [9:0] k);
    in_item_t it;
    it = '0;
    it.opcode       = op;
    it.key          = k;
    it.runs_in      = 16'($urandom);
    it.wickets_in   = 12'($urandom);
    it.matches_in   = 12'($urandom);
    it.field_select = 2'($urandom_range(2));
    it.descending   = 1'($urandom);
    it.new_value    = 16'($urandom);
    it.list_limit   = 7'($urandom_range(0, 40));
    return it;
  endfunction

  // Random but mostly well-formed: keys mostly drawn from those present.
  function automatic in_item_t random_cmd();
    in_item_t it;
    int r;
    r = $urandom_range(99);
    it = cmd(3'd0, 10'($urandom));
    if (r < 35) it.opcode = OP_ADD;
    else if (r < 50) it.opcode = OP_REMOVE;
    else if (r < 62) it.opcode = OP_FIND;
    else if (r < 78) it.opcode = OP_UPDATE;
    else if (r < 86) it.opcode = OP_SORT;
    else if (r < 96) it.opcode = OP_LIST;
    else it.opcode = 3'(6 + $urandom_range(1));
    if (key_pool.size() > 0 && $urandom_range(99) < 60)
      it.key = key_pool[$urandom_range(key_pool.size() - 1)];
    else if ($urandom_range(3) == 0) it.key = 10'd1023;
    if ($urandom_range(9) == 0) it.field_select = 2'd3;
    if ($urandom_range(7) == 0) it.list_limit = 7'($urandom);
    if (it.opcode == OP_ADD) key_pool.push_back(it.key);
    return it;
  endfunction

  initial begin
    in_item_t it;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty listing, misses, extremes, duplicate, full, saturation.
    it = cmd(OP_LIST, 10'd0); it.list_limit = 7'd64; send(it);
    it = cmd(OP_FIND, 10'd5); send(it);
    it = cmd(OP_ADD, 10'd0); it.runs_in = '0; it.wickets_in = '0; it.matches_in = '0;
    send(it);
    it = cmd(OP_ADD, 10'd1023); it.runs_in = '1; it.wickets_in = '1; it.matches_in = '1;
    send(it);
    it = cmd(OP_ADD, 10'd0); send(it);
    it = cmd(OP_UPDATE, 10'd0); it.field_select = SEL_WICKETS; it.new_value = '1; send(it);
    it = cmd(OP_UPDATE, 10'd0); it.field_select = SEL_MATCHES; it.new_value = 16'd4095;
    send(it);
    it = cmd(OP_UPDATE, 10'd0); it.field_select = SEL_RUNS; it.new_value = 16'hFFFF; send(it);
    it = cmd(OP_UPDATE, 10'd1023); it.field_select = 2'd3; send(it);
    it = cmd(OP_UPDATE, 10'd77); send(it);
    it = cmd(3'd6, 10'd0); send(it);
    it = cmd(3'd7, 10'd0); send(it);
    it = cmd(OP_SORT, 10'd0); it.field_select = 2'd3; it.list_limit = 0; send(it);
    it = cmd(OP_REMOVE, 10'd0); send(it);
    it = cmd(OP_REMOVE, 10'd0); send(it);
    for (int i = 0; i < 32; i++) begin
      it = cmd(OP_ADD, 10'(i * 31 + 1)); send(it);
    end
    it = cmd(OP_ADD, 10'd999); send(it);
    it = cmd(OP_SORT, 10'd0); it.field_select = SEL_RUNS; it.descending = 1;
    it.list_limit = 7'd127; send(it);
    it = cmd(OP_SORT, 10'd0); it.field_select = SEL_MATCHES; it.descending = 0;
    it.list_limit = 7'd32; send(it);
    for (int i = 0; i < 32; i++) key_pool.push_back(10'(i * 31 + 1));

    // Pause until the table has drained its results.
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    // Random with a stretch of back-to-back commands.
    for (int n = 0; n < 220; n++) begin
      quiet_stretch = (n >= 100 && n < 150);
      send(random_cmd());
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
